// ===== rtl/pnm_pkg.sv =====
`timescale 1ns / 1ps
package pnm_pkg;
    localparam int NumberBitsDefault = 16;
    localparam int LeftBits = 34;

    localparam logic [1:0] RK_HEADER = 2'd0;
    localparam logic [1:0] RK_SAMPLE = 2'd1;
    localparam logic [1:0] RK_ERROR  = 2'd2;

    localparam logic [2:0] ERR_MAGIC = 3'd0;
    localparam logic [2:0] ERR_TYPE  = 3'd1;
    localparam logic [2:0] ERR_RAWMAX = 3'd2;
    localparam logic [2:0] ERR_NUMBER = 3'd3;
    localparam logic [2:0] ERR_TRUNC = 3'd4;

    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NL = 8'h0a;

    typedef enum logic [2:0] {
        PH_MAGIC, PH_TYPE, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_ASCII, PH_RAW, PH_DONE
    } phase_t;

    // controller -> datapath
    typedef struct packed {
        logic       acc_clear;
        logic       acc_digit;
        logic [3:0] digit;
        logic       set_type;
        logic [1:0] type_ch;
        logic       type_raw;
        logic       load_width;
        logic       load_height;
        logic       load_maxval;
        logic       start_count;
        logic       count_step;
        logic       count_clear;
        logic       start_scale;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       digit_seen;
        logic       raw;
        logic       acc_zero;
        logic       acc_over255;
        logic       acc_eq255;
        logic       count_busy;
        logic       count_zero;
        logic       left_one;
        logic       left_is_zero_after;
        logic       scale_busy;
        logic [7:0] scale_out;
    } stat_t;

    function automatic logic is_space(input logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0a || b == 8'h0b
            || b == 8'h0c || b == 8'h0d;
    endfunction
endpackage

// ===== rtl/pnm_datapath.sv =====
`timescale 1ns / 1ps
module pnm_datapath import pnm_pkg::*; #(
    parameter int NUMBER_BITS = NumberBitsDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    output logic [15:0] width_q,
    output logic [15:0] height_q,
    output logic [15:0] maxval_q,
    output logic [1:0]  channels_q
);
    localparam int NB = NUMBER_BITS;
    localparam logic [NB-1:0] NumLimit = {NB{1'b1}};
    localparam int PB = 2 * NB + 2;

    logic [NB-1:0] acc_reg, acc_next;
    logic          seen_reg;
    logic [NB-1:0] w_reg, h_reg, m_reg;
    logic [1:0]    ch_reg;
    logic          raw_reg;
    logic [LeftBits-1:0] left_reg;
    logic [NB+3:0] mul10;

    // product count: wh = w*h is registered first, then times channels into left_reg
    logic [1:0]    cnt_state_reg;
    logic [2*NB-1:0] wh_reg;

    // scale: restoring divide of v*255 by maxval, one bit per cycle
    logic          sc_busy_reg;
    logic [5:0]    sc_cnt_reg;
    logic [NB+8:0] sc_rem_reg;
    logic [NB+7:0] sc_num_reg;
    logic [NB+7:0] sc_quo_reg;
    logic [7:0]    sc_out;
    logic [NB+8:0] sc_trial;

    assign mul10 = {4'd0, acc_reg} * (NB+4)'(10) + (NB+4)'(cmd.digit);
    always_comb
    begin
        acc_next = (mul10 > {4'd0, NumLimit}) ? NumLimit : mul10[NB-1:0];
    end

    assign sc_trial = {sc_rem_reg[NB+7:0], sc_num_reg[NB+7]};

    logic [PB-1:0] prod3;
    logic [LeftBits-1:0] left_sat;
    assign prod3 = {2'd0, wh_reg} * PB'(ch_reg);
    always_comb
    begin
        if (prod3 > PB'({LeftBits{1'b1}}))
            left_sat = {LeftBits{1'b1}};
        else
            left_sat = prod3[LeftBits-1:0];
    end

    always_comb
    begin
        if (m_reg == NB'(255))
            sc_out = acc_reg[7:0];
        else if (m_reg == '0)
            sc_out = 8'hff;
        else if (sc_quo_reg > (NB+8)'(255))
            sc_out = 8'hff;
        else
            sc_out = sc_quo_reg[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            seen_reg <= 1'b0;
            w_reg <= '0;
            h_reg <= '0;
            m_reg <= '0;
            ch_reg <= '0;
            raw_reg <= 1'b0;
            left_reg <= '0;
            cnt_state_reg <= '0;
            sc_busy_reg <= 1'b0;
            sc_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.acc_clear)
            begin
                acc_reg <= '0;
                seen_reg <= 1'b0;
            end
            else if (cmd.acc_digit)
            begin
                acc_reg <= acc_next;
                seen_reg <= 1'b1;
            end
            if (cmd.set_type)
            begin
                ch_reg <= cmd.type_ch;
                raw_reg <= cmd.type_raw;
            end
            if (cmd.load_width) w_reg <= acc_reg;
            if (cmd.load_height) h_reg <= acc_reg;
            if (cmd.load_maxval) m_reg <= acc_reg;
            if (cmd.start_count)
                cnt_state_reg <= 2'd1;
            else if (cnt_state_reg == 2'd1)
            begin
                wh_reg <= {{NB{1'b0}}, w_reg} * {{NB{1'b0}}, h_reg};
                cnt_state_reg <= 2'd2;
            end
            else if (cnt_state_reg == 2'd2)
            begin
                left_reg <= left_sat;
                cnt_state_reg <= 2'd0;
            end
            else if (cmd.count_clear)
                left_reg <= '0;
            else if (cmd.count_step && left_reg != '0)
                left_reg <= left_reg - 1'b1;
            if (cmd.start_scale)
            begin
                sc_busy_reg <= 1'b1;
                sc_cnt_reg <= 6'(NB + 8);
                sc_rem_reg <= '0;
                sc_quo_reg <= '0;
                sc_num_reg <= {acc_reg, 8'd0} - {8'd0, acc_reg};
            end
            else if (sc_busy_reg)
            begin
                sc_num_reg <= {sc_num_reg[NB+6:0], 1'b0};
                if (sc_trial >= {9'd0, m_reg})
                begin
                    sc_rem_reg <= sc_trial - {9'd0, m_reg};
                    sc_quo_reg <= {sc_quo_reg[NB+6:0], 1'b1};
                end
                else
                begin
                    sc_rem_reg <= sc_trial;
                    sc_quo_reg <= {sc_quo_reg[NB+6:0], 1'b0};
                end
                sc_cnt_reg <= sc_cnt_reg - 1'b1;
                if (sc_cnt_reg == 6'd1)
                    sc_busy_reg <= 1'b0;
            end
        end
    end

    assign stat.digit_seen = seen_reg;
    assign stat.raw = raw_reg;
    assign stat.acc_zero = (acc_reg == '0);
    assign stat.acc_over255 = (acc_reg > NB'(255));
    assign stat.acc_eq255 = (acc_reg == NB'(255));
    assign stat.count_busy = (cnt_state_reg != 2'd0);
    assign stat.count_zero = (left_reg == '0);
    assign stat.left_one = (left_reg == LeftBits'(1));
    assign stat.left_is_zero_after = (left_reg <= LeftBits'(1));
    assign stat.scale_busy = sc_busy_reg;
    assign stat.scale_out = sc_out;

    assign width_q = 16'(w_reg);
    assign height_q = 16'(h_reg);
    assign maxval_q = 16'(m_reg);
    assign channels_q = ch_reg;
endmodule

// ===== rtl/pnm_control.sv =====
`timescale 1ns / 1ps
module pnm_control import pnm_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] res_kind,
    output logic       res_warn,
    output logic [7:0] res_value,
    output logic       res_last,
    output logic [2:0] res_err,
    output cmd_t       cmd,
    input  stat_t      stat
);
    typedef enum logic [1:0] {S_RUN, S_COUNT, S_SCALE} ctl_t;

    phase_t phase_reg, phase_next;
    ctl_t   ctl_reg, ctl_next;
    logic   comment_reg, comment_next;
    logic   sc_last_reg, sc_last_next;
    logic   ov_reg, ov_next;
    logic [1:0] rk_reg, rk_next;
    logic   warn_reg, warn_next;
    logic [7:0] val_reg, val_next;
    logic   last_reg, last_next;
    logic [2:0] err_reg, err_next;
    logic   acc;
    logic   out_free;
    logic [7:0] d;

    assign out_free = !ov_reg || !out_stall;
    assign in_stall = (ctl_reg != S_RUN) || !out_free;
    assign acc = in_valid && !in_stall;
    assign d = data_byte - CH_ZERO;

    always_comb
    begin
        phase_next = phase_reg;
        ctl_next = ctl_reg;
        comment_next = comment_reg;
        sc_last_next = sc_last_reg;
        ov_next = ov_reg && out_stall;
        rk_next = rk_reg; warn_next = warn_reg; val_next = val_reg;
        last_next = last_reg; err_next = err_reg;
        cmd = '0;
        cmd.digit = d[3:0];
        case (ctl_reg)
            S_COUNT:
            begin
                if (!stat.count_busy && out_free)
                begin
                    ov_next = 1'b1;
                    rk_next = RK_HEADER; val_next = '0; last_next = 1'b0; err_next = '0;
                    phase_next = stat.count_zero ? PH_DONE : (stat.raw ? PH_RAW : PH_ASCII);
                    ctl_next = S_RUN;
                end
            end
            S_SCALE:
            begin
                if (!stat.scale_busy && out_free)
                begin
                    ov_next = 1'b1;
                    rk_next = RK_SAMPLE; warn_next = 1'b0; val_next = stat.scale_out;
                    last_next = sc_last_reg; err_next = '0;
                    cmd.acc_clear = 1'b1;
                    ctl_next = S_RUN;
                end
            end
            default:
            begin
                if (acc)
                begin
                    rk_next = RK_ERROR; warn_next = 1'b0; val_next = '0;
                    last_next = 1'b0;
                    if (kind)
                    begin
                        cmd.acc_clear = 1'b1;
                        comment_next = 1'b0;
                        phase_next = PH_MAGIC;
                        if (phase_reg == PH_ASCII && stat.digit_seen && stat.left_one)
                        begin
                            cmd.acc_clear = 1'b0;
                            cmd.count_clear = 1'b1;
                            cmd.start_scale = 1'b1;
                            sc_last_next = 1'b1;
                            ctl_next = S_SCALE;
                        end
                        else if (phase_reg != PH_MAGIC && phase_reg != PH_DONE)
                        begin
                            ov_next = 1'b1; err_next = ERR_TRUNC;
                        end
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_MAGIC:
                                if (data_byte != CH_P)
                                begin
                                    ov_next = 1'b1; err_next = ERR_MAGIC; phase_next = PH_DONE;
                                end
                                else
                                    phase_next = PH_TYPE;
                            PH_TYPE:
                                if (d >= 8'd1 && d <= 8'd7)
                                begin
                                    cmd.set_type = 1'b1;
                                    cmd.type_raw = (d >= 8'd4);
                                    cmd.type_ch = (d >= 8'd4) ? d[2:1] : d[1:0];
                                    cmd.acc_clear = 1'b1;
                                    comment_next = 1'b0;
                                    phase_next = PH_WIDTH;
                                end
                                else
                                begin
                                    ov_next = 1'b1; err_next = ERR_TYPE; phase_next = PH_DONE;
                                end
                            PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_ASCII:
                                if (comment_reg)
                                begin
                                    if (data_byte == CH_NL) comment_next = 1'b0;
                                end
                                else if (d <= 8'd9)
                                    cmd.acc_digit = 1'b1;
                                else if (!stat.digit_seen)
                                begin
                                    if (data_byte == CH_HASH) comment_next = 1'b1;
                                    else if (!is_space(data_byte))
                                    begin
                                        ov_next = 1'b1; err_next = ERR_NUMBER;
                                        phase_next = PH_DONE; cmd.acc_clear = 1'b1;
                                    end
                                end
                                else if (!(phase_reg == PH_MAXVAL && stat.raw)
                                         && data_byte != CH_HASH && !is_space(data_byte))
                                begin
                                    ov_next = 1'b1; err_next = ERR_NUMBER;
                                    phase_next = PH_DONE; cmd.acc_clear = 1'b1;
                                end
                                else
                                begin
                                    if (!(phase_reg == PH_MAXVAL && stat.raw)
                                        && data_byte == CH_HASH)
                                        comment_next = 1'b1;
                                    case (phase_reg)
                                        PH_WIDTH:
                                        begin
                                            cmd.load_width = 1'b1; cmd.acc_clear = 1'b1;
                                            phase_next = PH_HEIGHT;
                                        end
                                        PH_HEIGHT:
                                        begin
                                            cmd.load_height = 1'b1; cmd.acc_clear = 1'b1;
                                            phase_next = PH_MAXVAL;
                                        end
                                        PH_MAXVAL:
                                        begin
                                            cmd.load_maxval = 1'b1; cmd.acc_clear = 1'b1;
                                            if (stat.raw && stat.acc_over255)
                                            begin
                                                ov_next = 1'b1; err_next = ERR_RAWMAX;
                                                phase_next = PH_DONE; comment_next = 1'b0;
                                            end
                                            else if (!stat.raw && stat.acc_zero)
                                            begin
                                                ov_next = 1'b1; err_next = ERR_NUMBER;
                                                phase_next = PH_DONE; comment_next = 1'b0;
                                            end
                                            else
                                            begin
                                                warn_next = stat.raw && !stat.acc_eq255;
                                                cmd.start_count = 1'b1;
                                                ctl_next = S_COUNT;
                                            end
                                        end
                                        default:
                                        begin
                                            cmd.start_scale = 1'b1;
                                            cmd.count_step = 1'b1;
                                            sc_last_next = stat.left_is_zero_after;
                                            if (stat.left_is_zero_after) phase_next = PH_DONE;
                                            ctl_next = S_SCALE;
                                        end
                                    endcase
                                end
                            PH_RAW:
                            begin
                                cmd.count_step = 1'b1;
                                ov_next = 1'b1; rk_next = RK_SAMPLE;
                                val_next = data_byte; err_next = '0;
                                last_next = stat.left_is_zero_after;
                                if (stat.left_is_zero_after) phase_next = PH_DONE;
                            end
                            default: ;
                        endcase
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAGIC;
            ctl_reg <= S_RUN;
            comment_reg <= 1'b0;
            sc_last_reg <= 1'b0;
            ov_reg <= 1'b0;
            rk_reg <= '0; warn_reg <= 1'b0; val_reg <= '0; last_reg <= 1'b0; err_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            ctl_reg <= ctl_next;
            comment_reg <= comment_next;
            sc_last_reg <= sc_last_next;
            ov_reg <= ov_next;
            rk_reg <= rk_next; warn_reg <= warn_next; val_reg <= val_next;
            last_reg <= last_next; err_reg <= err_next;
        end
    end

    assign out_valid = ov_reg;
    assign res_kind = rk_reg;
    assign res_warn = warn_reg;
    assign res_value = val_reg;
    assign res_last = last_reg;
    assign res_err = err_reg;
endmodule

// ===== rtl/pnm_stream_parser.sv =====
`timescale 1ns / 1ps
// Byte-serial PNM (P1..P7) header and sample parser. Header and raw bytes are taken
// without a wait unless the output stalls. The header result waits for the
// sample-count multiply. Each ASCII sample ends with a bit-serial restoring divide for
// the maxval scaling, during which input stalls.
module pnm_stream_parser import pnm_pkg::*; #(
    parameter int NUMBER_BITS = NumberBitsDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [15:0] image_width,
    output logic [15:0] image_height,
    output logic [15:0] max_value,
    output logic [1:0]  channel_count,
    output logic        raw_mode,
    output logic        scaled_raw_warning,
    output logic [7:0]  sample_value,
    output logic        sample_last,
    output logic [2:0]  error_code
);
    cmd_t  cmd;
    stat_t stat;
    logic [15:0] w, h, m;
    logic [1:0]  ch;
    logic        hdr;

    pnm_control u_ctl (
        .clk, .rst_n, .in_valid, .in_stall, .kind, .data_byte,
        .out_valid, .out_stall, .res_kind(result_kind), .res_warn(scaled_raw_warning),
        .res_value(sample_value), .res_last(sample_last), .res_err(error_code),
        .cmd, .stat
    );

    pnm_datapath #(.NUMBER_BITS(NUMBER_BITS)) u_dp (
        .clk, .rst_n, .cmd, .stat,
        .width_q(w), .height_q(h), .maxval_q(m), .channels_q(ch)
    );

    assign hdr = (result_kind == RK_HEADER);
    assign image_width = hdr ? w : 16'd0;
    assign image_height = hdr ? h : 16'd0;
    assign max_value = hdr ? m : 16'd0;
    assign channel_count = hdr ? ch : 2'd0;
    assign raw_mode = hdr ? stat.raw : 1'b0;
endmodule

// ===== rtl/pnm_checker.sv =====
`timescale 1ns / 1ps
module pnm_checker import pnm_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] result_kind,
    input logic [7:0] sample_value,
    input logic       sample_last,
    input logic [2:0] error_code
);
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (result_kind != 2'd3)) else $error("bad result kind");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_kind)) else $error("beat dropped");
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == RK_ERROR |-> error_code <= ERR_TRUNC)
        else $error("bad error code");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != RK_SAMPLE |-> !sample_last && sample_value == 8'd0)
        else $error("sample fields leak");
endmodule

bind pnm_stream_parser pnm_checker u_chk (
    .clk, .rst_n, .out_valid, .out_stall, .result_kind,
    .sample_value, .sample_last, .error_code
);
